// ----- rtl/address_zone_table_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the zone table controller.
// ---------------------------------------------------------------------------
`ifndef ADDRESS_ZONE_TABLE_MACROS_SVH
`define ADDRESS_ZONE_TABLE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define AZT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AZT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/azt_pkg.sv -----
// ---------------------------------------------------------------------------
// azt_pkg
// Types and constants of the address zone table.
// ---------------------------------------------------------------------------
package azt_pkg;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_AROUND = 3'd3,
    ACT_LOOKUP = 3'd4
  } action_t;

  // All-ones address; the around trackers read it as unset.
  localparam logic [63:0] ADDR_UNSET = 64'hFFFF_FFFF_FFFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // capture the transaction and clear the trackers
    logic scan;      // examine the entry read in the previous cycle
    logic rd_en;     // read the entry at the scan index
    logic shift;     // move the entry read into the slot before it
    logic append;    // write a new zone at the end
    logic widen;     // write widened bounds of the matched entry
    logic clear;     // empty the table
    logic del_done;  // drop one from the count
    logic finish;    // load the result register
  } azt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;     // the entry examined holds the key
    logic last;      // scan index reached the count
    logic full;      // table is full
  } azt_sts_t;

endpackage

// ----- rtl/azt_datapath.sv -----
// ---------------------------------------------------------------------------
// azt_datapath
// Zone memories, scan index, around trackers and the result register.
// ---------------------------------------------------------------------------
module azt_datapath #(
  parameter int MAX_ZONES = 64,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  azt_pkg::azt_cmd_t  cmd,
  output azt_pkg::azt_sts_t  sts,
  input  logic [2:0]         in_action,
  input  logic [15:0]        in_zone_key,
  input  logic [63:0]        in_address,
  output logic               res_ok,
  output logic               res_prev_found,
  output logic [15:0]        res_prev_key,
  output logic               res_next_found,
  output logic [15:0]        res_next_key,
  output logic [63:0]        res_zone_low,
  output logic [63:0]        res_zone_high
);
  import azt_pkg::*;

  logic [15:0] mem_key [MAX_ZONES];
  logic [63:0] mem_low [MAX_ZONES];
  logic [63:0] mem_high[MAX_ZONES];

  logic [2:0]  act_r;
  logic [15:0] key_r;
  logic [63:0] addr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] ridx_r;
  logic [15:0] rk_r;
  logic [63:0] rl_r, rh_r;
  logic [63:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic        pf_r, pf_nxt, nf_r, nf_nxt, found_r, found_nxt;
  logic [15:0] pk_r, pk_nxt, nk_r, nk_nxt;
  logic [IW-1:0] midx_r, midx_nxt;
  logic [63:0] ml_r, ml_nxt, mh_r, mh_nxt;
  logic        match;
  logic        ok_sel, is_around, is_lookup;

  assign match = (rk_r == key_r);
  assign sts.match = match;
  assign sts.last  = (idx_r >= cnt_r);
  assign sts.full  = (cnt_r == CW'(MAX_ZONES));

  // Memory port: one read, one write per cycle.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rk_r <= mem_key[idx_r[IW-1:0]];
      rl_r <= mem_low[idx_r[IW-1:0]];
      rh_r <= mem_high[idx_r[IW-1:0]];
    end
    if (cmd.shift) begin
      mem_key[ridx_r - IW'(1)]  <= rk_r;
      mem_low[ridx_r - IW'(1)]  <= rl_r;
      mem_high[ridx_r - IW'(1)] <= rh_r;
    end else if (cmd.append) begin
      mem_key[cnt_r[IW-1:0]]  <= key_r;
      mem_low[cnt_r[IW-1:0]]  <= addr_r;
      mem_high[cnt_r[IW-1:0]] <= addr_r;
    end else if (cmd.widen) begin
      mem_low[midx_r]  <= (addr_r < ml_r) ? addr_r : ml_r;
      mem_high[midx_r] <= (addr_r > mh_r) ? addr_r : mh_r;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear) cnt_nxt = '0;
    else if (cmd.append) cnt_nxt = cnt_r + CW'(1);
    else if (cmd.del_done) cnt_nxt = cnt_r - CW'(1);
    idx_nxt = cmd.start ? '0 : (cmd.rd_en ? idx_r + CW'(1) : idx_r);
  end

  // Scan step: key search or the around trackers.
  always_comb begin
    lo_nxt = lo_r; hi_nxt = hi_r; pf_nxt = pf_r; nf_nxt = nf_r;
    pk_nxt = pk_r; nk_nxt = nk_r; found_nxt = found_r;
    midx_nxt = midx_r; ml_nxt = ml_r; mh_nxt = mh_r;
    if (cmd.start) begin
      lo_nxt = ADDR_UNSET; hi_nxt = ADDR_UNSET; pf_nxt = 1'b0; nf_nxt = 1'b0;
      pk_nxt = '0; nk_nxt = '0; found_nxt = 1'b0;
    end else if (cmd.scan) begin
      if (act_r == ACT_AROUND) begin
        if (rl_r > addr_r && (hi_nxt == ADDR_UNSET || rl_r < hi_nxt)) begin
          hi_nxt = rl_r; nk_nxt = rk_r; nf_nxt = 1'b1;
        end
        if (rl_r < addr_r && (lo_nxt == ADDR_UNSET || rl_r >= lo_nxt)) begin
          lo_nxt = rl_r; pk_nxt = rk_r; pf_nxt = 1'b1;
        end
        if (rh_r <= addr_r && (lo_nxt == ADDR_UNSET || rh_r >= lo_nxt)) begin
          lo_nxt = rh_r; pk_nxt = rk_r; pf_nxt = 1'b1;
        end
        if (rh_r > addr_r && (hi_nxt == ADDR_UNSET || rh_r < hi_nxt)) begin
          hi_nxt = rh_r; nk_nxt = rk_r; nf_nxt = 1'b1;
        end
      end else if (match && !found_r) begin
        found_nxt = 1'b1; midx_nxt = ridx_r; ml_nxt = rl_r; mh_nxt = rh_r;
      end
    end
    // An appended zone also makes the add succeed.
    if (cmd.append) found_nxt = 1'b1;
  end

  assign is_around = (act_r == ACT_AROUND);
  assign is_lookup = (act_r == ACT_LOOKUP);

  always_comb begin
    unique case (act_r)
      ACT_ADD, ACT_DELETE, ACT_LOOKUP: ok_sel = found_r;
      ACT_CLEAR:  ok_sel = 1'b1;
      ACT_AROUND: ok_sel = pf_r | nf_r;
      default:    ok_sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.rd_en) ridx_r <= idx_r[IW-1:0];
    if (cmd.start) begin
      act_r <= in_action; key_r <= in_zone_key; addr_r <= in_address;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; pf_r <= pf_nxt; nf_r <= nf_nxt;
    pk_r <= pk_nxt; nk_r <= nk_nxt; found_r <= found_nxt;
    midx_r <= midx_nxt; ml_r <= ml_nxt; mh_r <= mh_nxt;
    if (cmd.finish) begin
      res_ok         <= ok_sel;
      res_prev_found <= is_around & pf_r;
      res_prev_key   <= is_around ? pk_r : '0;
      res_next_found <= is_around & nf_r;
      res_next_key   <= is_around ? nk_r : '0;
      res_zone_low   <= (is_lookup && found_r) ? ml_r : '0;
      res_zone_high  <= (is_lookup && found_r) ? mh_r : '0;
    end
  end

endmodule

// ----- rtl/azt_ctrl.sv -----
// ---------------------------------------------------------------------------
// azt_ctrl
// Sequencer for the table operations.
// ---------------------------------------------------------------------------
`include "address_zone_table_macros.svh"
module azt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic               out_valid,
  input  logic               out_stall,
  output logic               load_out,
  input  azt_pkg::azt_sts_t  sts,
  output azt_pkg::azt_cmd_t  cmd
);
  import azt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DEL   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] act_r;
  logic       vld_r;   // a read was issued last cycle
  logic       vld_nxt;
  logic       hit_r, hit_nxt;

  // The output register is free when empty or being drained.
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    vld_nxt = 1'b0;
    hit_nxt = hit_r;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          hit_nxt = 1'b0;
          if (in_action == ACT_CLEAR) cmd.clear = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (vld_r) cmd.scan = 1'b1;
        if (vld_r && sts.match && act_r != ACT_AROUND) hit_nxt = 1'b1;
        if (vld_r && sts.match && act_r == ACT_DELETE && !hit_r) begin
          state_nxt = S_DEL;
        end else if (!sts.last && act_r != ACT_CLEAR && act_r <= ACT_LOOKUP) begin
          cmd.rd_en = 1'b1;
          vld_nxt = 1'b1;
        end else if (!vld_r) begin
          state_nxt = (act_r == ACT_ADD) ? S_WRITE : S_DONE;
        end
      end
      S_DEL: begin
        if (vld_r) cmd.shift = 1'b1;
        if (!sts.last) begin
          cmd.rd_en = 1'b1;
          vld_nxt = 1'b1;
        end else if (!vld_r) begin
          cmd.del_done = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_WRITE: begin
        if (hit_r) cmd.widen = 1'b1;
        else if (!sts.full) cmd.append = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r <= vld_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) act_r <= in_action;
  end

  `AZT_ASSERT(a_onehot, clk, rst_n, $onehot(state_r), "state is not one-hot")
  `AZT_ASSERT(a_one_write, clk, rst_n, $onehot0({cmd.shift, cmd.append, cmd.widen}),
    "two memory writes at once")
  `AZT_ASSERT_NEXT(a_start_busy, clk, rst_n, cmd.start, in_stall, "not busy after start")

endmodule

// ----- rtl/address_zone_table.sv -----
// ---------------------------------------------------------------------------
// address_zone_table
// Keyed, ordered table of address zones with add, delete, clear,
// lookup and nearest-boundary queries.
// ---------------------------------------------------------------------------
// Throughput: one transaction at a time, accepted the cycle after the previous result is
// loaded; add, delete, around and lookup scan the stored zones first, and a finished
// result waits in S_DONE while the output register is full and out_stall holds.
// Reset (synchronous, rst_n low) empties the table and clears out_valid; the memories are not.
module address_zone_table #(
  parameter int MAX_ZONES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_zone_key,
  input  logic [63:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic        out_prev_found,
  output logic [15:0] out_prev_key,
  output logic        out_next_found,
  output logic [15:0] out_next_key,
  output logic [63:0] out_zone_low,
  output logic [63:0] out_zone_high
);
  import azt_pkg::*;

  // Index width for the memories and count width that can hold MAX_ZONES.
  localparam int IW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CW = $clog2(MAX_ZONES + 1) + 1;

  azt_cmd_t cmd;
  azt_sts_t sts;
  logic     load_out;
  logic     out_valid_r;

  // The controller sequences each transaction; the datapath holds the
  // table and writes its result register when the controller finishes.
  azt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid_r),
    .out_stall (out_stall),
    .load_out  (load_out),
    .sts       (sts),
    .cmd       (cmd)
  );

  azt_datapath #(
    .MAX_ZONES (MAX_ZONES),
    .IW        (IW),
    .CW        (CW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_action),
    .in_zone_key    (in_zone_key),
    .in_address     (in_address),
    .res_ok         (out_ok),
    .res_prev_found (out_prev_found),
    .res_prev_key   (out_prev_key),
    .res_next_found (out_next_found),
    .res_next_key   (out_next_key),
    .res_zone_low   (out_zone_low),
    .res_zone_high  (out_zone_high)
  );

  // The valid flag is set when the result register is loaded and stays set until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- tb/sv/zone_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zone table checker
// Watches both channels of the address zone table, keeps its own copy of the
// table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module zone_table_checker #(
  parameter int MAX_ZONES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_zone_key,
  input  logic [63:0] in_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_ok,
  input  logic        out_prev_found,
  input  logic [15:0] out_prev_key,
  input  logic        out_next_found,
  input  logic [15:0] out_next_key,
  input  logic [63:0] out_zone_low,
  input  logic [63:0] out_zone_high,
  output int          error_count,
  output int          pending_count,
  output int          zone_count
);
  import azt_pkg::*;

  typedef struct packed {
    logic        ok;
    logic        prev_found;
    logic [15:0] prev_key;
    logic        next_found;
    logic [15:0] next_key;
    logic [63:0] zone_low;
    logic [63:0] zone_high;
  } zone_answer_t;

  logic [15:0] keys [MAX_ZONES];
  logic [63:0] lows [MAX_ZONES];
  logic [63:0] highs[MAX_ZONES];
  int          count;
  zone_answer_t answers[$];

  assign pending_count = answers.size();
  assign zone_count    = count;

  function automatic int find_zone(logic [15:0] key);
    for (int i = 0; i < count; i++) if (keys[i] == key) return i;
    return -1;
  endfunction

  // Applies one transaction to the table copy and returns its answer.
  function automatic zone_answer_t apply_zone_op(logic [2:0] act, logic [15:0] key,
                                                 logic [63:0] addr);
    zone_answer_t r;
    int idx;
    logic [63:0] lo, hi, a, b;
    r = '0;
    idx = find_zone(key);
    case (act)
      ACT_ADD: begin
        if (idx >= 0) begin
          if (addr < lows[idx]) lows[idx] = addr;
          if (addr > highs[idx]) highs[idx] = addr;
          r.ok = 1'b1;
        end else if (count < MAX_ZONES) begin
          keys[count] = key;
          lows[count] = addr;
          highs[count] = addr;
          count++;
          r.ok = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (idx >= 0) begin
          for (int i = idx; i + 1 < count; i++) begin
            keys[i] = keys[i+1];
            lows[i] = lows[i+1];
            highs[i] = highs[i+1];
          end
          count--;
          r.ok = 1'b1;
        end
      end
      ACT_CLEAR: begin
        count = 0;
        r.ok = 1'b1;
      end
      ACT_AROUND: begin
        lo = ADDR_UNSET;
        hi = ADDR_UNSET;
        for (int i = 0; i < count; i++) begin
          a = lows[i];
          b = highs[i];
          if (a > addr && (hi == ADDR_UNSET || a < hi)) begin
            hi = a; r.next_key = keys[i]; r.next_found = 1'b1;
          end
          if (a < addr && (lo == ADDR_UNSET || a >= lo)) begin
            lo = a; r.prev_key = keys[i]; r.prev_found = 1'b1;
          end
          if (b <= addr && (lo == ADDR_UNSET || b >= lo)) begin
            lo = b; r.prev_key = keys[i]; r.prev_found = 1'b1;
          end
          if (b > addr && (hi == ADDR_UNSET || b < hi)) begin
            hi = b; r.next_key = keys[i]; r.next_found = 1'b1;
          end
        end
        r.ok = r.prev_found | r.next_found;
      end
      ACT_LOOKUP: begin
        if (idx >= 0) begin
          r.ok = 1'b1;
          r.zone_low = lows[idx];
          r.zone_high = highs[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    zone_answer_t want, got;
    if (!rst_n) begin
      count = 0;
      answers.delete();
      error_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_ok, out_prev_found, out_prev_key, out_next_found, out_next_key,
                out_zone_low, out_zone_high};
        if (answers.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, got);
          error_count <= error_count + 1;
        end else begin
          want = answers.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            error_count <= error_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        answers.push_back(apply_zone_op(in_action, in_zone_key, in_address));
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address zone table testbench
// Drives directed and random table operations with random idling on both
// channels; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import azt_pkg::*;

  localparam int MAX_ZONES = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [15:0] in_zone_key = '0;
  logic [63:0] in_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok, out_prev_found, out_next_found;
  logic [15:0] out_prev_key, out_next_key;
  logic [63:0] out_zone_low, out_zone_high;
  int          error_count, pending_count, zone_count;

  // Idle rates in percent for the sender and the receiver, and a flag that
  // lets the receiver hold off for a long stretch.
  int send_idle_pct = 11;
  int recv_idle_pct = 72;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  // A small key pool makes adds widen existing zones and deletes hit often.
  logic [15:0] key_pool[8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                               16'h1234, 16'h00FF, 16'hAAAA, 16'h5555};

  always #5 clk = ~clk;

  address_zone_table #(.MAX_ZONES(MAX_ZONES)) DUT (.*);

  zone_table_checker #(.MAX_ZONES(MAX_ZONES)) checker_i (.*);

  // The receiver stalls at random; during a hold-off it stalls for a long,
  // counted stretch so the block fills up and pushes back on its input.
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
      for (int i = 0; i < 300; i++) @(negedge clk);
      out_stall <= 1'b0;
      hold_off = 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // The watchdog counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one transaction after a random gap and waits until it is accepted.
  task automatic send_op(logic [2:0] act, logic [15:0] key, logic [63:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_zone_key = key;
    in_address = addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [63:0] pick_address();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return ADDR_UNSET;
      2: return 64'(ADDR_UNSET - $urandom_range(3));
      3: return 64'($urandom_range(40));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [2:0] pick_action(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < 2) return 3'($urandom_range(7, 5));
    if (r < 3) return ACT_CLEAR;
    if (filling ? r < 60 : r < 30) return ACT_ADD;
    if (r < 70) return ACT_DELETE;
    if (r < 88) return ACT_AROUND;
    return ACT_LOOKUP;
  endfunction

  task automatic random_ops(int n);
    logic [15:0] key;
    for (int i = 0; i < n; i++) begin
      key = ($urandom_range(1)) ? key_pool[$urandom_range(7)]
                                : 16'($urandom_range(MAX_ZONES + 10));
      if ($urandom_range(9) == 0) key = 16'($urandom);
      send_op(pick_action(zone_count < 40), key, pick_address());
    end
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: queries on an empty table, extremes of every field, the
    // all-ones sentinel collision, widening, missing keys and unused codes.
    send_op(ACT_AROUND, 16'h0000, 64'd5);
    send_op(ACT_LOOKUP, 16'h0001, 64'd0);
    send_op(ACT_DELETE, 16'h0001, 64'd0);
    send_op(ACT_ADD, 16'hFFFF, ADDR_UNSET);
    send_op(ACT_ADD, 16'h0000, 64'd0);
    send_op(ACT_ADD, 16'h0001, 64'd100);
    send_op(ACT_ADD, 16'h0001, 64'd50);
    send_op(ACT_ADD, 16'h0001, 64'd200);
    send_op(ACT_AROUND, 16'h0000, 64'd100);
    send_op(ACT_AROUND, 16'h0000, ADDR_UNSET);
    send_op(ACT_AROUND, 16'h0000, 64'd0);
    send_op(ACT_LOOKUP, 16'h0001, 64'd0);
    send_op(ACT_LOOKUP, 16'hFFFF, 64'd0);
    send_op(ACT_DELETE, 16'h0000, 64'd0);
    send_op(ACT_AROUND, 16'hFFFF, 64'd75);
    send_op(3'd5, 16'hFFFF, ADDR_UNSET);
    send_op(3'd6, 16'h5555, 64'd1);
    send_op(3'd7, 16'hAAAA, 64'd2);
    send_op(ACT_CLEAR, 16'h0000, 64'd0);
    send_op(ACT_AROUND, 16'h0000, 64'd1);

    // Fill the table to the brim, then one more new key must be refused.
    for (int i = 0; i < MAX_ZONES; i++)
      send_op(ACT_ADD, 16'(i + 16'h0100), {$urandom, $urandom});
    send_op(ACT_ADD, 16'hBEEF, 64'd7);
    send_op(ACT_AROUND, 16'h0000, 64'h8000_0000_0000_0000);
    send_op(ACT_DELETE, 16'h0100, 64'd0);

    // The sender pauses here until every result has come back.
    wait_drained();

    // Long receiver hold-off while the sender keeps offering transactions.
    hold_off = 1'b1;
    random_ops(60);
    random_ops(390);

    send_idle_pct = 72;
    recv_idle_pct = 11;
    random_ops(450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_ops(400);

    wait_drained();
    repeat (2 * MAX_ZONES + 10) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
